// File: rtl/vma_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vma_pkg
// Widths, CORDIC turn table and pipeline stage type for the
// Cartesian-to-polar converter.
// ----------------------------------------------------------------------------
package vma_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int ANGLE_WIDTH  = 16;
    localparam int LENGTH_W     = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int PRE_SHIFT    = 16;
    localparam int ZW           = 32;

    localparam int CXW = COORD_WIDTH + PRE_SHIFT + 3;
    localparam int SQW = 2 * COORD_WIDTH;
    localparam int NST = (CORDIC_STEPS > COORD_WIDTH + 1) ? CORDIC_STEPS : COORD_WIDTH + 1;

    localparam logic [LENGTH_W-1:0] LENGTH_MAX = {LENGTH_W{1'b1}};
    localparam logic [ZW-1:0]       HALF_TURN  = 32'h8000_0000;
    localparam logic [ZW-1:0]       Z_ROUND    =
        (ANGLE_WIDTH < ZW) ? (32'd1 << (ZW - 1 - ANGLE_WIDTH)) : 32'd0;

    // round(atan(2^-i) / (2*pi) * 2^32)
    localparam logic [ZW-1:0] TURN_ATAN [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic                  is_zero;
        logic signed [CXW-1:0] cx;
        logic signed [CXW-1:0] cy;
        logic [ZW-1:0]         z;
        logic [SQW-1:0]        rem;
        logic [SQW:0]          root;
    } t_stage;

endpackage
`default_nettype wire

// File: rtl/vector_magnitude_angle_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vector_magnitude_angle_top
// Cartesian-to-polar conversion: rounded magnitude and heading of a Q1.14 point.
// ----------------------------------------------------------------------------
// One point is taken per clock; busy is always low. Each result appears on
// o_length / o_heading / o_is_zero for one cycle with o_valid high, in order,
// after the input register, the NST stage registers and the output register.
// The depth is set by the 24 CORDIC rotation stages, one per register stage;
// the bit-per-stage square root runs beside them. Results cannot be held off.
// ----------------------------------------------------------------------------
module vector_magnitude_angle_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [vma_pkg::COORD_WIDTH-1:0]  i_x_coord,
    input  wire logic [vma_pkg::COORD_WIDTH-1:0]  i_y_coord,
    output logic                                  o_valid,
    output logic [vma_pkg::LENGTH_W-1:0]          o_length,
    output logic [vma_pkg::ANGLE_WIDTH-1:0]       o_heading,
    output logic                                  o_is_zero
);
    import vma_pkg::*;

    localparam int LAT = NST + 2;

    t_stage                r_st [0:NST];
    logic [NST:0]          r_vld;
    logic [SQW-1:0]        r_xx;
    logic [SQW-1:0]        r_yy;

    logic signed [COORD_WIDTH-1:0] w_x;
    logic signed [COORD_WIDTH-1:0] w_y;
    logic signed [CXW-1:0]         w_xe;
    logic signed [CXW-1:0]         w_ye;
    logic signed [SQW-1:0]         w_xx;
    logic signed [SQW-1:0]         w_yy;
    t_stage                        n_st0;

    assign busy = 1'b0;
    assign w_x  = i_x_coord;
    assign w_y  = i_y_coord;
    assign w_xe = {{(CXW-COORD_WIDTH-PRE_SHIFT){w_x[COORD_WIDTH-1]}}, w_x, {PRE_SHIFT{1'b0}}};
    assign w_ye = {{(CXW-COORD_WIDTH-PRE_SHIFT){w_y[COORD_WIDTH-1]}}, w_y, {PRE_SHIFT{1'b0}}};
    assign w_xx = w_x * w_x;
    assign w_yy = w_y * w_y;

    // fold left half-plane into the right one
    always_comb begin
        n_st0.is_zero = (i_x_coord == '0) && (i_y_coord == '0);
        n_st0.rem     = '0;
        n_st0.root    = '0;
        if (w_x[COORD_WIDTH-1]) begin
            n_st0.cx = -w_xe;
            n_st0.cy = -w_ye;
            n_st0.z  = HALF_TURN;
        end else begin
            n_st0.cx = w_xe;
            n_st0.cy = w_ye;
            n_st0.z  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st[0] <= n_st0;
        r_xx    <= $unsigned(w_xx);
        r_yy    <= $unsigned(w_yy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= start;
        end
    end

    for (genvar k = 1; k <= NST; k++) begin : g_stage
        localparam int J = k - 1;

        logic signed [CXW-1:0] n_cx;
        logic signed [CXW-1:0] n_cy;
        logic [ZW-1:0]         n_z;
        logic [SQW-1:0]        n_rem;
        logic [SQW:0]          n_root;
        t_stage                w_prv;

        assign w_prv = r_st[k-1];

        if (J < CORDIC_STEPS) begin : g_rot
            logic signed [CXW-1:0] w_dx;
            logic signed [CXW-1:0] w_dy;
            assign w_dx = w_prv.cx >>> J;
            assign w_dy = w_prv.cy >>> J;
            always_comb begin
                if (w_prv.cy > 0) begin
                    n_cx = w_prv.cx + w_dy;
                    n_cy = w_prv.cy - w_dx;
                    n_z  = w_prv.z + TURN_ATAN[J];
                end else begin
                    n_cx = w_prv.cx - w_dy;
                    n_cy = w_prv.cy + w_dx;
                    n_z  = w_prv.z - TURN_ATAN[J];
                end
            end
        end else begin : g_rot_hold
            assign n_cx = w_prv.cx;
            assign n_cy = w_prv.cy;
            assign n_z  = w_prv.z;
        end

        if (k == 1) begin : g_sum
            assign n_rem  = r_xx + r_yy;
            assign n_root = '0;
        end else if (k <= COORD_WIDTH + 1) begin : g_root
            localparam logic [SQW:0] BIT = (SQW+1)'(1) << (SQW - 2 - 2 * (k - 2));
            logic [SQW:0] w_trial;
            assign w_trial = w_prv.root + BIT;
            always_comb begin
                if ({1'b0, w_prv.rem} >= w_trial) begin
                    n_rem  = w_prv.rem - w_trial[SQW-1:0];
                    n_root = (w_prv.root >> 1) + BIT;
                end else begin
                    n_rem  = w_prv.rem;
                    n_root = w_prv.root >> 1;
                end
            end
        end else begin : g_root_hold
            assign n_rem  = w_prv.rem;
            assign n_root = w_prv.root;
        end

        always_ff @(posedge i_clk) begin
            r_st[k] <= '{is_zero: w_prv.is_zero, cx: n_cx, cy: n_cy, z: n_z,
                         rem: n_rem, root: n_root};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // output word: round root, saturate, round turn; a zero vector gives zeros
    t_stage                  w_fin;
    logic [SQW:0]            w_len;
    logic [ZW-1:0]           w_zr;
    logic [LENGTH_W-1:0]     n_length;
    logic [ANGLE_WIDTH-1:0]  n_heading;
    logic                    r_valid;
    logic [LENGTH_W-1:0]     r_length;
    logic [ANGLE_WIDTH-1:0]  r_heading;
    logic                    r_is_zero;

    assign w_fin = r_st[NST];
    assign w_len = w_fin.root + (SQW+1)'({1'b0, w_fin.rem} > w_fin.root);
    assign w_zr  = w_fin.z + Z_ROUND;

    always_comb begin
        if (w_fin.is_zero) begin
            n_length  = '0;
            n_heading = '0;
        end else begin
            n_length  = (w_len > (SQW+1)'(LENGTH_MAX)) ? LENGTH_MAX : w_len[LENGTH_W-1:0];
            n_heading = w_zr[ZW-1 -: ANGLE_WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        r_length  <= n_length;
        r_heading <= n_heading;
        r_is_zero <= w_fin.is_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_vld[NST];
        end
    end

    assign o_valid   = r_valid;
    assign o_length  = r_length;
    assign o_heading = r_heading;
    assign o_is_zero = r_is_zero;

    a_lat_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result word without matching start");

    a_lat_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_valid)
        else $error("accepted word produced no result");

    a_zero_match : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_zero == $past((i_x_coord == '0) && (i_y_coord == '0), LAT)))
        else $error("zero flag does not match input word");

    a_zero_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_zero) |-> (o_length == '0) && (o_heading == '0))
        else $error("zero vector with nonzero length or heading");

    a_len_nz : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_zero) |-> (o_length != '0))
        else $error("nonzero vector with zero length");

endmodule
`default_nettype wire
